// ===== rtl/core/byte_budget_lru_cache_directory_macros.svh =====
// Assertion macros for the cache directory RTL.
`ifndef BYTE_BUDGET_LRU_CACHE_DIRECTORY_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_DIRECTORY_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define BBLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
// Check that a condition never holds outside reset.
`define BBLC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define BBLC_ASSERT(lbl, prop)
`define BBLC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/bblc_pkg.sv =====
// Types, constants and helpers of the byte-budget LRU cache directory.
`default_nettype none
package bblc_pkg;

  localparam int unsigned ENTRIES     = 32;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned TAG_W       = 64;
  localparam int unsigned BYTES_W     = 24;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ECNT_W      = 6;
  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 232;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam logic [WORD_W-1:0] BUDGET_RESET = 32'd104857600;
  localparam logic [WORD_W-1:0] SAT_MAX      = '1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_GET      = 3'd0,
    REQ_CONTAINS = 3'd1,
    REQ_PUT      = 3'd2,
    REQ_REMOVE   = 3'd3,
    REQ_FLUSH    = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_DONE   = 2'd0,
    RS_MISS   = 2'd1,
    RS_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_EVICT,
    S_EMIT
  } fsm_e;

  typedef enum logic [2:0] {
    ROW_NOP,
    ROW_CLEAR,
    ROW_FLUSH,
    ROW_KILL,
    ROW_PROMOTE
  } row_op_e;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [BYTES_W-1:0] bytes;
    logic               dirty;
  } entry_t;

  typedef struct packed {
    row_op_e op;
    logic    shift;
    logic    kill;
  } cell_ctl_t;

  typedef struct packed {
    row_op_e            op;
    logic [ENTRIES-1:0] tgt;
    logic [ENTRIES-1:0] kill;
    entry_t             head;
  } row_cmd_t;

  typedef struct packed {
    logic [ENTRIES-1:0] hit_vec;
    logic               hit_any;
    entry_t             hit_ent;
    logic [ENTRIES-1:0] victim_vec;
    logic               victim_any;
    entry_t             victim_ent;
    logic [ENTRIES-1:0] hole_vec;
    logic [CNT_W-1:0]   dirty_cnt;
  } row_stat_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bblc_cell.sv =====
// One recency cell: holds the entry at one rank and shifts from its neighbor.
`default_nettype none
module bblc_cell
  import bblc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctl_t        ctl_i,
  input  wire entry_t           prev_i,
  input  wire logic [TAG_W-1:0] key_i,
  output entry_t                ent_o,
  output logic                  hit_o
);

  logic               valid_q, valid_d;
  logic               dirty_q, dirty_d;
  logic [TAG_W-1:0]   tag_q;
  logic [BYTES_W-1:0] bytes_q;

  // Update valid and dirty marks
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    case (ctl_i.op)
      ROW_CLEAR: begin
        valid_d = 1'b0;
        dirty_d = 1'b0;
      end
      ROW_FLUSH: dirty_d = 1'b0;
      ROW_KILL: begin
        if (ctl_i.kill) begin
          valid_d = 1'b0;
          dirty_d = 1'b0;
        end
      end
      ROW_PROMOTE: begin
        if (ctl_i.shift) begin
          valid_d = prev_i.valid;
          dirty_d = prev_i.dirty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  // Take tag and size from the neighbor on a shift
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == ROW_PROMOTE && ctl_i.shift) begin
      tag_q   <= prev_i.tag;
      bytes_q <= prev_i.bytes;
    end
  end

  assign ent_o = '{valid: valid_q, tag: tag_q, bytes: bytes_q, dirty: dirty_q};
  assign hit_o = valid_q && (tag_q == key_i);

endmodule
`default_nettype wire

// ===== rtl/core/bblc_cell_row.sv =====
// Row of recency cells, rank 0 most recent, with hit, victim and hole search.
`default_nettype none
module bblc_cell_row
  import bblc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire row_cmd_t           cmd_i,
  input  wire logic [TAG_W-1:0]   key_i,
  input  wire logic [ENTRIES-1:0] keep_i,
  output row_stat_t               stat_o
);

  entry_t             ent_w  [ENTRIES];
  entry_t             prev_w [ENTRIES];
  logic [ENTRIES-1:0] hit_w;
  logic [ENTRIES-1:0] valid_w;
  logic [ENTRIES-1:0] shift_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] cand_rev;
  logic [ENTRIES-1:0] iso_rev;
  logic [ENTRIES-1:0] victim_vec;
  entry_t             hit_ent;
  entry_t             victim_ent;
  logic [CNT_W-1:0]   dirty_cnt;

  // Shift every rank from the head down to the target rank
  assign shift_vec = (cmd_i.tgt << 1) - 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl = '{op: cmd_i.op, shift: shift_vec[i], kill: cmd_i.kill[i]};
    if (i == 0) begin : g_head
      assign prev_w[i] = cmd_i.head;
    end else begin : g_link
      assign prev_w[i] = ent_w[i-1];
    end
    bblc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev_w[i]),
      .key_i  (key_i),
      .ent_o  (ent_w[i]),
      .hit_o  (hit_w[i])
    );
    assign valid_w[i]  = ent_w[i].valid;
    assign cand_rev[i] = ent_w[ENTRIES-1-i].valid && !keep_i[ENTRIES-1-i];
  end

  // Lowest free rank absorbs the shift on insert
  assign free_vec = ~valid_w;

  // Oldest valid rank outside the protected entry
  assign iso_rev = cand_rev & (~cand_rev + 1'b1);
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = iso_rev[ENTRIES-1-i];
    end
  end

  // Select hit and victim entries, count dirty entries
  always_comb begin
    hit_ent    = '0;
    victim_ent = '0;
    dirty_cnt  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_ent    = hit_ent | (hit_w[i] ? ent_w[i] : '0);
      victim_ent = victim_ent | (victim_vec[i] ? ent_w[i] : '0);
      dirty_cnt  = dirty_cnt + CNT_W'(ent_w[i].valid && ent_w[i].dirty);
    end
  end

  assign stat_o = '{
    hit_vec:    hit_w,
    hit_any:    |hit_w,
    hit_ent:    hit_ent,
    victim_vec: victim_vec,
    victim_any: |cand_rev,
    victim_ent: victim_ent,
    hole_vec:   free_vec & (~free_vec + 1'b1),
    dirty_cnt:  dirty_cnt
  };

endmodule
`default_nettype wire

// ===== rtl/core/byte_budget_lru_cache_directory.sv =====
// Top level of the byte-budget LRU cache directory.
// Usage: write byte_budget through cfg_we_i / cfg_wdata_i while idle (zero
// selects the reset budget of 104857600). Send requests on the s_axis
// channel: tuser carries req_type, tdata carries key_tag, entry_bytes and
// mark_dirty. Every request returns one or more beats on m_axis; each
// eviction of a put is one beat, and the final beat has tlast high. All
// beats of a request carry the status and totals after the request.
// Timing: one request at a time. A request is looked up in the cell row
// in S_LOOK after acceptance and executed in S_EXEC; a nonzero put then
// runs the S_EVICT loop, which drops victims one at a time and then
// places or rejects the entry. Results leave from S_EMIT at one beat per
// cycle while the receiver is ready; the next request is taken in the
// cycle after its last beat is loaded into the output register.
// Throughput is set by this sequence and by the one-victim-per-cycle
// eviction loop.
// Reset empties the directory, clears all counters and restores the
// budget. A stalled receiver holds the output register; evictions wait
// in the victim buffer and the block takes no request until all beats
// are loaded.
`default_nettype none
`include "byte_budget_lru_cache_directory_macros.svh"
module byte_budget_lru_cache_directory
  import bblc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [WORD_W-1:0]      cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // key_tag [63:0], entry_bytes [87:64], mark_dirty [88]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type [2:0]
  input  wire logic [TYPE_W-1:0]      s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // evicted_tag [63:0], evicted_bytes [87:64], evicted_dirty [88],
  // flushed_count [94:89], used_bytes [126:95], entry_count [132:127],
  // hit_total [164:133], miss_total [196:165], evict_total [228:197]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // status [1:0], evict_valid [2]
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
  output logic                        m_axis_tlast
);

  fsm_e               state_q, state_d;
  logic [TYPE_W-1:0]  req_q;
  logic [TAG_W-1:0]   tag_q;
  logic [BYTES_W-1:0] nbytes_q;
  logic               mark_q;
  logic [ENTRIES-1:0] hit_vec_q;
  logic               hit_any_q;
  entry_t             hit_ent_q;
  logic [WORD_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [WORD_W-1:0]  hit_cnt_q, hit_cnt_d;
  logic [WORD_W-1:0]  miss_cnt_q, miss_cnt_d;
  logic [WORD_W-1:0]  evict_cnt_q, evict_cnt_d;
  status_e            status_q, status_d;
  logic [CNT_W-1:0]   flushed_q, flushed_d;
  logic [WORD_W-1:0]  budget_q;
  logic [CNT_W-1:0]   vbuf_wr_q, vbuf_rd_q;
  logic [TAG_W-1:0]   vbuf_tag   [ENTRIES];
  logic [BYTES_W-1:0] vbuf_bytes [ENTRIES];
  logic               vbuf_dirty [ENTRIES];
  logic               out_valid_q;
  logic               out_last_q;
  logic [OUT_TUSER_W-1:0] out_user_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  row_cmd_t           cmd;
  row_stat_t          stat;
  logic               push;
  logic               out_free;
  logic               vbuf_empty;
  logic [BYTES_W-1:0] need;
  logic               over;
  logic               full;
  logic               load_victim;
  logic               load_final;

  bblc_cell_row u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .key_i  (tag_q),
    .keep_i (hit_vec_q),
    .stat_o (stat)
  );

  // Budget check for the put loop; an entry that does not grow needs no room
  assign need = !hit_any_q ? nbytes_q :
                (nbytes_q > hit_ent_q.bytes) ? nbytes_q - hit_ent_q.bytes : '0;
  assign over = (need != '0) &&
                (({1'b0, used_q} + (WORD_W+1)'(need)) > {1'b0, budget_q});
  assign full = (count_q == CNT_W'(ENTRIES));

  assign out_free    = !out_valid_q || m_axis_tready;
  assign vbuf_empty  = (vbuf_rd_q == vbuf_wr_q);
  assign load_victim = (state_q == S_EMIT) && out_free && !vbuf_empty;
  assign load_final  = (state_q == S_EMIT) && out_free && vbuf_empty;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_LOOK;
      S_LOOK: state_d = S_EXEC;
      S_EXEC: begin
        if (req_q == REQ_PUT && nbytes_q != '0) state_d = S_EVICT;
        else state_d = S_EMIT;
      end
      S_EVICT: begin
        if (!(over && stat.victim_any) && (over || hit_any_q || !full)) state_d = S_EMIT;
      end
      S_EMIT: if (load_final) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Row commands and totals
  always_comb begin
    cmd         = '{op: ROW_NOP, tgt: '0, kill: '0, head: '0};
    push        = 1'b0;
    used_d      = used_q;
    count_d     = count_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    status_d    = status_q;
    flushed_d   = flushed_q;
    if (state_q == S_LOOK) begin
      status_d  = RS_DONE;
      flushed_d = '0;
    end
    if (state_q == S_EXEC) begin
      case (req_q)
        REQ_GET: begin
          if (hit_any_q) begin
            cmd.op      = ROW_PROMOTE;
            cmd.tgt     = hit_vec_q;
            cmd.head    = hit_ent_q;
            hit_cnt_d   = sat_inc(hit_cnt_q);
          end else begin
            status_d   = RS_MISS;
            miss_cnt_d = sat_inc(miss_cnt_q);
          end
        end
        REQ_CONTAINS: status_d = hit_any_q ? RS_DONE : RS_MISS;
        REQ_PUT: if (nbytes_q == '0) status_d = RS_REJECT;
        REQ_REMOVE: begin
          if (hit_any_q) begin
            cmd.op   = ROW_KILL;
            cmd.kill = hit_vec_q;
            used_d   = used_q - WORD_W'(hit_ent_q.bytes);
            count_d  = count_q - 1'b1;
          end else begin
            status_d = RS_MISS;
          end
        end
        REQ_FLUSH: begin
          cmd.op    = ROW_FLUSH;
          flushed_d = stat.dirty_cnt;
        end
        REQ_CLEAR: begin
          cmd.op  = ROW_CLEAR;
          used_d  = '0;
          count_d = '0;
        end
        default: status_d = RS_REJECT;
      endcase
    end
    if (state_q == S_EVICT) begin
      if ((over && stat.victim_any) || (!over && !hit_any_q && full)) begin
        // Drop the oldest unprotected entry and log it
        cmd.op      = ROW_KILL;
        cmd.kill    = stat.victim_vec;
        push        = 1'b1;
        used_d      = used_q - WORD_W'(stat.victim_ent.bytes);
        count_d     = count_q - 1'b1;
        evict_cnt_d = sat_inc(evict_cnt_q);
      end else if (over) begin
        status_d = RS_REJECT;
      end else if (hit_any_q) begin
        // Resize in place and move to most recent
        cmd.op         = ROW_PROMOTE;
        cmd.tgt        = hit_vec_q;
        cmd.head       = hit_ent_q;
        cmd.head.bytes = nbytes_q;
        cmd.head.dirty = hit_ent_q.dirty | mark_q;
        used_d         = used_q - WORD_W'(hit_ent_q.bytes) + WORD_W'(nbytes_q);
      end else begin
        // Insert at the head, absorbing the shift in the first free rank
        cmd.op   = ROW_PROMOTE;
        cmd.tgt  = stat.hole_vec;
        cmd.head = '{valid: 1'b1, tag: tag_q, bytes: nbytes_q, dirty: mark_q};
        used_d   = used_q + WORD_W'(nbytes_q);
        count_d  = count_q + 1'b1;
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      status_q    <= RS_DONE;
      flushed_q   <= '0;
      budget_q    <= BUDGET_RESET;
      vbuf_wr_q   <= '0;
      vbuf_rd_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      status_q    <= status_d;
      flushed_q   <= flushed_d;
      if (cfg_we_i) begin
        budget_q <= (cfg_wdata_i != '0) ? cfg_wdata_i : BUDGET_RESET;
      end
      if (push) vbuf_wr_q <= vbuf_wr_q + 1'b1;
      if (load_victim) vbuf_rd_q <= vbuf_rd_q + 1'b1;
      if (load_final) begin
        vbuf_wr_q <= '0;
        vbuf_rd_q <= '0;
      end
      if (load_victim || load_final) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Request and lookup capture
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q    <= s_axis_tuser;
      tag_q    <= s_axis_tdata[TAG_W-1:0];
      nbytes_q <= s_axis_tdata[TAG_W +: BYTES_W];
      mark_q   <= s_axis_tdata[TAG_W+BYTES_W];
    end
    if (state_q == S_LOOK) begin
      hit_vec_q <= stat.hit_vec;
      hit_any_q <= stat.hit_any;
      hit_ent_q <= stat.hit_ent;
    end
  end

  // Victim buffer
  always_ff @(posedge clk_i) begin
    if (push) begin
      vbuf_tag[vbuf_wr_q[IDX_W-1:0]]   <= stat.victim_ent.tag;
      vbuf_bytes[vbuf_wr_q[IDX_W-1:0]] <= stat.victim_ent.bytes;
      vbuf_dirty[vbuf_wr_q[IDX_W-1:0]] <= stat.victim_ent.dirty;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_victim || load_final) begin
      out_last_q <= load_final;
      out_user_q <= {load_victim, status_q};
      out_data_q <= {3'b0, evict_cnt_q, miss_cnt_q, hit_cnt_q, ECNT_W'(count_q), used_q,
                     ECNT_W'(flushed_q),
                     load_victim ? vbuf_dirty[vbuf_rd_q[IDX_W-1:0]] : 1'b0,
                     load_victim ? vbuf_bytes[vbuf_rd_q[IDX_W-1:0]] : '0,
                     load_victim ? vbuf_tag[vbuf_rd_q[IDX_W-1:0]] : '0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  `BBLC_ASSERT_NEVER(a_vbuf_bound, vbuf_wr_q > CNT_W'(ENTRIES))
  `BBLC_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(ENTRIES))
  `BBLC_ASSERT(a_hit_onehot, (state_q == S_EXEC) |-> $onehot0(hit_vec_q))
  `BBLC_ASSERT(a_evict_only_in_loop, (state_q != S_EVICT) |=> $stable(evict_cnt_q))

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the byte-budget LRU cache directory.
`timescale 1ns / 100ps
module tb;
  import bblc_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_SPARE7 = 3'd7;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct {
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                ev_valid;
    logic [TAG_W-1:0]    ev_tag;
    logic [BYTES_W-1:0]  ev_bytes;
    logic                ev_dirty;
    logic [ECNT_W-1:0]   flushed;
    logic [WORD_W-1:0]   used;
    logic [ECNT_W-1:0]   count;
    logic [WORD_W-1:0]   hits;
    logic [WORD_W-1:0]   misses;
    logic [WORD_W-1:0]   evicts;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [WORD_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [TYPE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  byte_budget_lru_cache_directory dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow directory state
  logic              dir_valid [ENTRIES];
  logic [TAG_W-1:0]  dir_tag   [ENTRIES];
  logic [BYTES_W-1:0] dir_bytes[ENTRIES];
  logic              dir_dirty [ENTRIES];
  int                lru_rank  [ENTRIES];
  logic [WORD_W-1:0] used_q, hits_q, misses_q, evicts_q, budget_q;

  beat_t pending_beats[$];
  beat_t victims[$];
  int errors = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;
  logic [TAG_W-1:0] tag_pool[40];

  task automatic report(input string what, input logic [TAG_W-1:0] got,
                        input logic [TAG_W-1:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [WORD_W-1:0] bump(input logic [WORD_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void promote(input int s);
    int p;
    p = 0;
    while (p < ENTRIES && lru_rank[p] != s) p++;
    if (p >= ENTRIES) p = ENTRIES - 1;
    for (int q = p; q > 0; q--) lru_rank[q] = lru_rank[q-1];
    lru_rank[0] = s;
  endfunction

  function automatic int oldest_live(input int keep);
    for (int p = ENTRIES - 1; p >= 0; p--)
      if (dir_valid[lru_rank[p]] && lru_rank[p] != keep) return lru_rank[p];
    return -1;
  endfunction

  function automatic void drop_victim(input int s);
    beat_t b;
    b = '{default: '0};
    b.ev_valid = 1'b1;
    b.ev_tag = dir_tag[s];
    b.ev_bytes = dir_bytes[s];
    b.ev_dirty = dir_dirty[s];
    victims.push_back(b);
    used_q -= dir_bytes[s];
    dir_valid[s] = 1'b0;
    dir_dirty[s] = 1'b0;
    evicts_q = bump(evicts_q);
  endfunction

  function automatic void reset_directory();
    for (int s = 0; s < ENTRIES; s++) begin
      dir_valid[s] = 1'b0;
      dir_dirty[s] = 1'b0;
      lru_rank[s] = s;
    end
    used_q = '0; hits_q = '0; misses_q = '0; evicts_q = '0;
    budget_q = BUDGET_RESET;
  endfunction

  // Work out every beat a request produces and queue them in order
  function automatic void predict_request(input logic [TYPE_W-1:0] req,
      input logic [TAG_W-1:0] tag, input logic [BYTES_W-1:0] nb, input logic md);
    int hit, f, v;
    logic [STATUS_W-1:0] st;
    logic [ECNT_W-1:0] fl, live;
    logic [63:0] need;
    beat_t b;
    st = RS_DONE; fl = '0; hit = -1; f = -1;
    victims.delete();
    for (int s = 0; s < ENTRIES; s++)
      if (hit < 0 && dir_valid[s] && dir_tag[s] == tag) hit = s;
    case (req)
      REQ_GET: begin
        if (hit >= 0) begin
          promote(hit);
          hits_q = bump(hits_q);
        end else begin
          st = RS_MISS;
          misses_q = bump(misses_q);
        end
      end
      REQ_CONTAINS: st = (hit >= 0) ? RS_DONE : RS_MISS;
      REQ_PUT: begin
        if (nb == 0) st = RS_REJECT;
        else if (hit >= 0) begin
          if (nb > dir_bytes[hit]) begin
            need = 64'(nb) - 64'(dir_bytes[hit]);
            while (64'(used_q) + need > 64'(budget_q)) begin
              v = oldest_live(hit);
              if (v < 0) break;
              drop_victim(v);
            end
            if (64'(used_q) + need > 64'(budget_q)) st = RS_REJECT;
          end
          if (st != RS_REJECT) begin
            used_q = used_q - dir_bytes[hit] + nb;
            dir_bytes[hit] = nb;
            dir_dirty[hit] |= md;
            promote(hit);
          end
        end else begin
          while (64'(used_q) + 64'(nb) > 64'(budget_q)) begin
            v = oldest_live(-1);
            if (v < 0) break;
            drop_victim(v);
          end
          if (64'(used_q) + 64'(nb) > 64'(budget_q)) st = RS_REJECT;
          else begin
            for (int s = 0; s < ENTRIES; s++)
              if (f < 0 && !dir_valid[s]) f = s;
            // full table: free the least-recent slot
            if (f < 0) begin
              f = oldest_live(-1);
              drop_victim(f);
            end
            dir_valid[f] = 1'b1;
            dir_tag[f] = tag;
            dir_bytes[f] = nb;
            dir_dirty[f] = md;
            used_q += nb;
            promote(f);
          end
        end
      end
      REQ_REMOVE: begin
        if (hit >= 0) begin
          used_q -= dir_bytes[hit];
          dir_valid[hit] = 1'b0;
          dir_dirty[hit] = 1'b0;
        end else st = RS_MISS;
      end
      REQ_FLUSH: begin
        for (int s = 0; s < ENTRIES; s++)
          if (dir_valid[s] && dir_dirty[s]) begin
            dir_dirty[s] = 1'b0;
            fl++;
          end
      end
      REQ_CLEAR: begin
        for (int s = 0; s < ENTRIES; s++) begin
          dir_valid[s] = 1'b0;
          dir_dirty[s] = 1'b0;
        end
        used_q = '0;
      end
      default: st = RS_REJECT;
    endcase
    live = '0;
    for (int s = 0; s < ENTRIES; s++) live += dir_valid[s];
    b = '{default: '0};
    victims.push_back(b);
    foreach (victims[j]) begin
      b = victims[j];
      b.last = (j == victims.size() - 1);
      b.status = st; b.flushed = fl; b.used = used_q; b.count = live;
      b.hits = hits_q; b.misses = misses_q; b.evicts = evicts_q;
      pending_beats.push_back(b);
    end
  endfunction

  // Offer one request beat and hold it until taken; returns at the accepting edge
  task automatic send_req(input logic [TYPE_W-1:0] req, input logic [TAG_W-1:0] tag,
                          input logic [BYTES_W-1:0] nb, input logic md);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {7'd0, md, nb, tag};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predict_request(req, tag, nb, md);
  endtask

  task automatic idle_gap(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop offering until every expected beat has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_budget(input logic [WORD_W-1:0] val);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    budget_q = (val == '0) ? BUDGET_RESET : val;
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(negedge clk_i) begin
    beat_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        $display("MISMATCH unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        w = pending_beats.pop_front();
        if (m_axis_tlast !== w.last) report("last", m_axis_tlast, w.last);
        if (m_axis_tuser[1:0] !== w.status) report("status", m_axis_tuser[1:0], w.status);
        if (m_axis_tuser[2] !== w.ev_valid) report("evict_valid", m_axis_tuser[2], w.ev_valid);
        if (m_axis_tdata[63:0] !== w.ev_tag) report("evicted_tag", m_axis_tdata[63:0], w.ev_tag);
        if (m_axis_tdata[87:64] !== w.ev_bytes)
          report("evicted_bytes", m_axis_tdata[87:64], w.ev_bytes);
        if (m_axis_tdata[88] !== w.ev_dirty) report("evicted_dirty", m_axis_tdata[88], w.ev_dirty);
        if (m_axis_tdata[94:89] !== w.flushed)
          report("flushed_count", m_axis_tdata[94:89], w.flushed);
        if (m_axis_tdata[126:95] !== w.used) report("used_bytes", m_axis_tdata[126:95], w.used);
        if (m_axis_tdata[132:127] !== w.count)
          report("entry_count", m_axis_tdata[132:127], w.count);
        if (m_axis_tdata[164:133] !== w.hits) report("hit_total", m_axis_tdata[164:133], w.hits);
        if (m_axis_tdata[196:165] !== w.misses)
          report("miss_total", m_axis_tdata[196:165], w.misses);
        if (m_axis_tdata[228:197] !== w.evicts)
          report("evict_total", m_axis_tdata[228:197], w.evicts);
      end
    end
  end

  // Watchdog: count stuck cycles while work is outstanding
  int stuck_cycles = 0;
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && pending_beats.size() == 0))
      stuck_cycles <= 0;
    else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("byte_budget_lru_cache_directory verification failed");
      $finish;
    end else
      stuck_cycles <= stuck_cycles + 1;
  end

  task automatic test_directed();
    send_req(REQ_GET, 64'd0, 24'd0, 1'b0);
    send_req(REQ_PUT, 64'd0, 24'd0, 1'b1);
    send_req(REQ_PUT, 64'd0, 24'd100, 1'b1);
    send_req(REQ_PUT, '1, 24'hFFFFFF, 1'b0);
    send_req(REQ_GET, '1, 24'd0, 1'b0);
    send_req(REQ_CONTAINS, 64'd0, 24'd0, 1'b0);
    send_req(REQ_CONTAINS, 64'd5, 24'd0, 1'b0);
    send_req(REQ_PUT, 64'd0, 24'd50, 1'b0);
    send_req(REQ_PUT, 64'd0, 24'd2000, 1'b0);
    send_req(REQ_FLUSH, 64'd0, 24'd0, 1'b0);
    send_req(REQ_FLUSH, 64'd0, 24'd0, 1'b0);
    send_req(REQ_REMOVE, 64'd0, 24'd0, 1'b0);
    send_req(REQ_REMOVE, 64'd0, 24'd0, 1'b0);
    send_req(REQ_SPARE6, 64'd0, 24'd0, 1'b0);
    send_req(REQ_SPARE7, '1, 24'hFFFFFF, 1'b1);
    send_req(REQ_CLEAR, 64'd0, 24'd0, 1'b0);
    // small budget: eviction order, protected resize, oversized entry
    write_budget(32'd1000);
    send_req(REQ_PUT, 64'hA, 24'd400, 1'b1);
    send_req(REQ_PUT, 64'hB, 24'd400, 1'b0);
    send_req(REQ_PUT, 64'hC, 24'd400, 1'b1);
    send_req(REQ_GET, 64'hB, 24'd0, 1'b0);
    send_req(REQ_PUT, 64'hB, 24'd900, 1'b0);
    send_req(REQ_PUT, 64'hD, 24'd5000, 1'b0);
    // lowest budget
    write_budget(32'd1);
    send_req(REQ_PUT, 64'h1, 24'd1, 1'b0);
    send_req(REQ_PUT, 64'h2, 24'd2, 1'b0);
    write_budget(32'd0);
  endtask

  task automatic test_random(input int n, input int max_bytes);
    int pick;
    logic [TYPE_W-1:0] req;
    logic [TAG_W-1:0] tag;
    logic [BYTES_W-1:0] nb;
    for (int i = 0; i < 40; i++) tag_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) req = REQ_PUT;
      else if (pick < 70) req = REQ_GET;
      else if (pick < 79) req = REQ_CONTAINS;
      else if (pick < 89) req = REQ_REMOVE;
      else if (pick < 95) req = REQ_FLUSH;
      else if (pick < 96) req = REQ_CLEAR;
      else if (pick < 98) req = REQ_SPARE6;
      else req = REQ_SPARE7;
      tag = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : tag_pool[$urandom_range(0, 39)];
      pick = $urandom_range(0, 49);
      if (pick == 0) nb = '0;
      else if (pick == 1) nb = 24'hFFFFFF;
      else if (pick == 2) nb = $urandom;
      else nb = $urandom_range(1, max_bytes);
      send_req(req, tag, nb, $urandom_range(0, 1));
      if (!calm && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
    end
  endtask

  // Stall the receiver while requests keep coming, then pause until drained
  task automatic test_backpressure();
    hold_long = 1'b1;
    for (int i = 0; i < 20; i++)
      send_req(REQ_PUT, {$urandom, $urandom}, $urandom_range(1, 6000), 1'b1);
    drain();
  endtask

  initial begin
    reset_directory();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(90, 2000);
    write_budget(32'd20000);
    test_random(80, 3000);
    test_backpressure();
    write_budget('1);
    test_random(40, 2000);
    write_budget(32'd8000);
    calm = 1'b1;
    test_random(60, 1500);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("byte_budget_lru_cache_directory verification clean");
    else
      $display("byte_budget_lru_cache_directory verification failed");
    $finish;
  end

endmodule
